@@ hw/rtl/rci_pkg.sv @@
// Shared widths, status codes and sideband types for the ray and cone intersection unit.
`timescale 1ns / 1ps

package rci_pkg;

    localparam int IN_W      = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W + 1;
    localparam int LO_W      = 32;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int D_W       = 2 * MAG_W + 2;
    localparam int ROOT_W    = D_W / 2;
    localparam int NUM_W     = ROOT_W + 2;
    localparam int NMAG_W    = NUM_W - 1;
    localparam int DEN_W     = MAG_W + 1;
    localparam int Q_W       = IN_W;
    localparam int REM_W     = DEN_W + Q_W;
    localparam int DIV_LAT   = Q_W + 3;

    typedef enum logic [1:0] {
        ST_MISS  = 2'd0,
        ST_HIT   = 2'd1,
        ST_DEGEN = 2'd2
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic signed [SUM_W-1:0]  b;
        logic                     a_neg;
        logic [MAG_W-1:0]         a_mag;
    } side_t;

endpackage

@@ hw/rtl/ray_cone_intersect_unit.sv @@
// Top level of the ray and unit double cone intersection pipeline.
//
//   channel   signals                                   direction   flow
//   request   start, busy, origin_*, direction_*        in          start while busy is low
//   result    done, hit_status, near_root, far_root     out         one-cycle strobe
//
// A new request is taken every cycle; busy stays low.
// A result passes through the coefficient stages, the 66-stage square root, the
// numerator register and the 35-stage divider, in that order.
// Reset clears every valid bit, so no result appears until a request has passed through.
// Nothing stalls: results are shown for exactly one cycle and the pipeline never waits.
`timescale 1ns / 1ps

module ray_cone_intersect_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [rci_pkg::IN_W-1:0]    origin_x,
    input  logic signed [rci_pkg::IN_W-1:0]    origin_y,
    input  logic signed [rci_pkg::IN_W-1:0]    origin_z,
    input  logic signed [rci_pkg::IN_W-1:0]    direction_x,
    input  logic signed [rci_pkg::IN_W-1:0]    direction_y,
    input  logic signed [rci_pkg::IN_W-1:0]    direction_z,
    output logic                               done,
    output logic [1:0]                         hit_status,
    output logic signed [rci_pkg::IN_W-1:0]    near_root,
    output logic signed [rci_pkg::IN_W-1:0]    far_root
);

    localparam int NW = rci_pkg::NUM_W;
    localparam int SW = rci_pkg::SUM_W;
    localparam int RW = rci_pkg::ROOT_W;
    localparam int DL = rci_pkg::DIV_LAT;

    logic                        quad_v;
    logic [rci_pkg::D_W-1:0]     quad_d;
    rci_pkg::side_t              quad_side;

    logic                        sq_v;
    logic [RW-1:0]               sq_root;
    rci_pkg::side_t              sq_side;

    logic                        num_v_reg;
    logic signed [NW-1:0]        near_num_reg, far_num_reg;
    logic signed [NW-1:0]        near_num_next, far_num_next, b_ext, s_ext;
    logic                        a_neg_reg;
    logic [rci_pkg::MAG_W-1:0]   a_mag_reg;
    rci_pkg::status_t            st_reg;
    rci_pkg::status_t            st_dly_reg [0:DL-1];

    logic                        near_v, far_v;
    logic signed [rci_pkg::Q_W-1:0] near_q, far_q;

    assign busy = 1'b0;

    rci_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .ox        (origin_x),
        .oy        (origin_y),
        .oz        (origin_z),
        .dx        (direction_x),
        .dy        (direction_y),
        .dz        (direction_z),
        .out_valid (quad_v),
        .d         (quad_d),
        .side      (quad_side)
    );

    rci_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quad_v),
        .d         (quad_d),
        .side_in   (quad_side),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    always_comb
    begin
        b_ext         = {{(NW-SW){sq_side.b[SW-1]}}, sq_side.b};
        s_ext         = {{(NW-RW){1'b0}}, sq_root};
        near_num_next = -b_ext - s_ext;
        far_num_next  = s_ext - b_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_v_reg <= 1'b0;
        end
        else
        begin
            num_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        near_num_reg <= near_num_next;
        far_num_reg  <= far_num_next;
        a_neg_reg    <= sq_side.a_neg;
        a_mag_reg    <= sq_side.a_mag;
        st_reg       <= sq_side.status;
        st_dly_reg[0] <= st_reg;
        for (int i = 1; i < DL; i++)
        begin
            st_dly_reg[i] <= st_dly_reg[i-1];
        end
    end

    rci_div u_div_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_v_reg),
        .num       (near_num_reg),
        .a_neg     (a_neg_reg),
        .a_mag     (a_mag_reg),
        .out_valid (near_v),
        .root      (near_q)
    );

    rci_div u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_v_reg),
        .num       (far_num_reg),
        .a_neg     (a_neg_reg),
        .a_mag     (a_mag_reg),
        .out_valid (far_v),
        .root      (far_q)
    );

    // Misses and degenerate rays report zero roots.
    assign done       = near_v & far_v;
    assign hit_status = st_dly_reg[DL-1];
    assign near_root  = (st_dly_reg[DL-1] == rci_pkg::ST_HIT) ? near_q : '0;
    assign far_root   = (st_dly_reg[DL-1] == rci_pkg::ST_HIT) ? far_q : '0;

endmodule

@@ hw/rtl/rci_quad.sv @@
// Front pipeline: products, quadratic coefficients and the discriminant.
`timescale 1ns / 1ps

module rci_quad (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [rci_pkg::IN_W-1:0]        ox,
    input  logic signed [rci_pkg::IN_W-1:0]        oy,
    input  logic signed [rci_pkg::IN_W-1:0]        oz,
    input  logic signed [rci_pkg::IN_W-1:0]        dx,
    input  logic signed [rci_pkg::IN_W-1:0]        dy,
    input  logic signed [rci_pkg::IN_W-1:0]        dz,
    output logic                                   out_valid,
    output logic [rci_pkg::D_W-1:0]                d,
    output rci_pkg::side_t                         side
);

    localparam int PW = rci_pkg::PROD_W;
    localparam int SW = rci_pkg::SUM_W;
    localparam int MW = rci_pkg::MAG_W;
    localparam int HW = rci_pkg::HI_W;
    localparam int LW = rci_pkg::LO_W;
    localparam int DW = rci_pkg::D_W;

    // Stage 1: the nine input products.
    logic               v1_reg;
    logic signed [PW-1:0] dxx_reg, dyy_reg, dzz_reg, oxdx_reg, oydy_reg, ozdz_reg;
    logic signed [PW-1:0] oxx_reg, oyy_reg, ozz_reg;
    logic signed [PW-1:0] dxx_next, dyy_next, dzz_next, oxdx_next, oydy_next, ozdz_next;
    logic signed [PW-1:0] oxx_next, oyy_next, ozz_next;

    // Stage 2: signed coefficients.
    logic               v2_reg;
    logic signed [SW-1:0] a_reg, b_reg, c_reg;
    logic signed [SW-1:0] a_next, b_next, c_next;

    // Stage 3: sign and magnitude.
    logic               v3_reg;
    logic               a_zero3_reg, a_neg3_reg, c_neg3_reg;
    logic [MW-1:0]      a_mag3_reg, b_mag3_reg, c_mag3_reg;
    logic signed [SW-1:0] b3_reg;
    logic signed [SW-1:0] a_abs_next, b_abs_next, c_abs_next;

    // Stage 4: partial products.
    logic               v4_reg;
    logic               a_zero4_reg, a_neg4_reg, ac_neg4_reg;
    logic [MW-1:0]      a_mag4_reg;
    logic signed [SW-1:0] b4_reg;
    logic [2*HW-1:0]    bhh_reg, ahh_reg;
    logic [HW+LW-1:0]   bhl_reg, ahl_reg, alh_reg;
    logic [2*LW-1:0]    bll_reg, all_reg;

    // Stage 5: full b^2 and 4ac products.
    logic               v5_reg;
    logic               a_zero5_reg, a_neg5_reg, ac_neg5_reg;
    logic [MW-1:0]      a_mag5_reg;
    logic signed [SW-1:0] b5_reg;
    logic [DW-1:0]      b2_reg, ac4_reg;
    logic [DW-1:0]      b2_next, ac_next;

    // Stage 6: discriminant and status.
    logic               v6_reg;
    logic [DW-1:0]      d_reg, d_next;
    rci_pkg::side_t     side_reg, side_next;

    always_comb
    begin
        dxx_next  = dx * dx;
        dyy_next  = dy * dy;
        dzz_next  = dz * dz;
        oxdx_next = ox * dx;
        oydy_next = oy * dy;
        ozdz_next = oz * dz;
        oxx_next  = ox * ox;
        oyy_next  = oy * oy;
        ozz_next  = oz * oz;
    end

    always_comb
    begin
        a_next = {{2{dxx_reg[PW-1]}}, dxx_reg} - {{2{dyy_reg[PW-1]}}, dyy_reg}
               + {{2{dzz_reg[PW-1]}}, dzz_reg};
        b_next = ({{2{oxdx_reg[PW-1]}}, oxdx_reg} - {{2{oydy_reg[PW-1]}}, oydy_reg}
               + {{2{ozdz_reg[PW-1]}}, ozdz_reg}) <<< 1;
        c_next = {{2{oxx_reg[PW-1]}}, oxx_reg} - {{2{oyy_reg[PW-1]}}, oyy_reg}
               + {{2{ozz_reg[PW-1]}}, ozz_reg};
    end

    always_comb
    begin
        a_abs_next = a_reg[SW-1] ? -a_reg : a_reg;
        b_abs_next = b_reg[SW-1] ? -b_reg : b_reg;
        c_abs_next = c_reg[SW-1] ? -c_reg : c_reg;
    end

    always_comb
    begin
        b2_next = ({{(DW-2*HW){1'b0}}, bhh_reg} << (2*LW))
                + ({{(DW-HW-LW){1'b0}}, bhl_reg} << (LW+1))
                + {{(DW-2*LW){1'b0}}, bll_reg};
        ac_next = ({{(DW-2*HW){1'b0}}, ahh_reg} << (2*LW))
                + ({{(DW-HW-LW){1'b0}}, ahl_reg} << LW)
                + ({{(DW-HW-LW){1'b0}}, alh_reg} << LW)
                + {{(DW-2*LW){1'b0}}, all_reg};
    end

    // A product a*c of opposite signs adds to b^2; otherwise it is subtracted.
    always_comb
    begin
        side_next.b     = b5_reg;
        side_next.a_neg = a_neg5_reg;
        side_next.a_mag = a_mag5_reg;
        if (ac_neg5_reg)
        begin
            d_next = b2_reg + ac4_reg;
        end
        else
        begin
            d_next = b2_reg - ac4_reg;
        end
        if (a_zero5_reg)
        begin
            side_next.status = rci_pkg::ST_DEGEN;
        end
        else if (!ac_neg5_reg && (b2_reg < ac4_reg))
        begin
            side_next.status = rci_pkg::ST_MISS;
        end
        else
        begin
            side_next.status = rci_pkg::ST_HIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dxx_reg  <= dxx_next;
        dyy_reg  <= dyy_next;
        dzz_reg  <= dzz_next;
        oxdx_reg <= oxdx_next;
        oydy_reg <= oydy_next;
        ozdz_reg <= ozdz_next;
        oxx_reg  <= oxx_next;
        oyy_reg  <= oyy_next;
        ozz_reg  <= ozz_next;

        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;

        a_zero3_reg <= (a_reg == '0);
        a_neg3_reg  <= a_reg[SW-1];
        c_neg3_reg  <= c_reg[SW-1];
        a_mag3_reg  <= a_abs_next[MW-1:0];
        b_mag3_reg  <= b_abs_next[MW-1:0];
        c_mag3_reg  <= c_abs_next[MW-1:0];
        b3_reg      <= b_reg;

        a_zero4_reg <= a_zero3_reg;
        a_neg4_reg  <= a_neg3_reg;
        ac_neg4_reg <= a_neg3_reg ^ c_neg3_reg;
        a_mag4_reg  <= a_mag3_reg;
        b4_reg      <= b3_reg;
        bhh_reg     <= b_mag3_reg[MW-1:LW] * b_mag3_reg[MW-1:LW];
        bhl_reg     <= b_mag3_reg[MW-1:LW] * b_mag3_reg[LW-1:0];
        bll_reg     <= b_mag3_reg[LW-1:0] * b_mag3_reg[LW-1:0];
        ahh_reg     <= a_mag3_reg[MW-1:LW] * c_mag3_reg[MW-1:LW];
        ahl_reg     <= a_mag3_reg[MW-1:LW] * c_mag3_reg[LW-1:0];
        alh_reg     <= a_mag3_reg[LW-1:0] * c_mag3_reg[MW-1:LW];
        all_reg     <= a_mag3_reg[LW-1:0] * c_mag3_reg[LW-1:0];

        a_zero5_reg <= a_zero4_reg;
        a_neg5_reg  <= a_neg4_reg;
        ac_neg5_reg <= ac_neg4_reg;
        a_mag5_reg  <= a_mag4_reg;
        b5_reg      <= b4_reg;
        b2_reg      <= b2_next;
        ac4_reg     <= ac_next << 2;

        d_reg    <= d_next;
        side_reg <= side_next;
    end

    assign out_valid = v6_reg;
    assign d         = d_reg;
    assign side      = side_reg;

endmodule

@@ hw/rtl/rci_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rci_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rci_pkg::D_W-1:0]       d,
    input  rci_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [rci_pkg::ROOT_W-1:0]    root,
    output rci_pkg::side_t                side_out
);

    localparam int DW = rci_pkg::D_W;
    localparam int RW = rci_pkg::ROOT_W;

    logic           v_reg    [1:RW];
    logic [DW-1:0]  x_reg    [1:RW];
    logic [DW-1:0]  res_reg  [1:RW];
    rci_pkg::side_t side_reg [1:RW];

    logic           v_st    [0:RW-1];
    logic [DW-1:0]  x_st    [0:RW-1];
    logic [DW-1:0]  res_st  [0:RW-1];
    rci_pkg::side_t side_st [0:RW-1];

    genvar g;
    generate
        for (g = 0; g < RW; g++)
        begin : g_stage
            localparam int K = RW - 1 - g;
            logic [DW-1:0] bit_w, trial, x_next, res_next;
            logic          ge;

            if (g == 0)
            begin : g_first
                assign v_st[g]    = in_valid;
                assign x_st[g]    = d;
                assign res_st[g]  = '0;
                assign side_st[g] = side_in;
            end
            else
            begin : g_rest
                assign v_st[g]    = v_reg[g];
                assign x_st[g]    = x_reg[g];
                assign res_st[g]  = res_reg[g];
                assign side_st[g] = side_reg[g];
            end

            // Each stage tries the next power of four against the remainder.
            always_comb
            begin
                bit_w = {{(DW-1){1'b0}}, 1'b1} << (2*K);
                trial = res_st[g] + bit_w;
                ge    = (x_st[g] >= trial);
                if (ge)
                begin
                    x_next   = x_st[g] - trial;
                    res_next = (res_st[g] >> 1) + bit_w;
                end
                else
                begin
                    x_next   = x_st[g];
                    res_next = res_st[g] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g+1] <= 1'b0;
                end
                else
                begin
                    v_reg[g+1] <= v_st[g];
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[g+1]    <= x_next;
                res_reg[g+1]  <= res_next;
                side_reg[g+1] <= side_st[g];
            end
        end
    endgenerate

    assign out_valid = v_reg[RW];
    assign root      = res_reg[RW][RW-1:0];
    assign side_out  = side_reg[RW];

endmodule

@@ hw/rtl/rci_div.sv @@
// Pipelined restoring divider for one root, with saturation to the signed result range.
`timescale 1ns / 1ps

module rci_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [rci_pkg::NUM_W-1:0]    num,
    input  logic                                a_neg,
    input  logic [rci_pkg::MAG_W-1:0]           a_mag,
    output logic                                out_valid,
    output logic signed [rci_pkg::Q_W-1:0]      root
);

    localparam int NW = rci_pkg::NUM_W;
    localparam int NM = rci_pkg::NMAG_W;
    localparam int EW = rci_pkg::DEN_W;
    localparam int QW = rci_pkg::Q_W;
    localparam int RW = rci_pkg::REM_W;
    localparam int FB = rci_pkg::FRAC_BITS;

    // Quotient sign, numerator magnitude and doubled denominator.
    logic             va_reg, nega_reg;
    logic [NM-1:0]    maga_reg;
    logic [EW-1:0]    dena_reg;
    logic signed [NW-1:0] abs_next;

    // Step registers; index 0 holds the scaled numerator and the overflow flag.
    logic             v_reg   [0:QW];
    logic             neg_reg [0:QW];
    logic             big_reg [0:QW];
    logic [RW-1:0]    rem_reg [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic [EW-1:0]    den_reg [0:QW];

    logic [RW-1:0]    numsh_next, dentop_next;

    logic             vo_reg;
    logic [QW-1:0]    root_reg, root_next;
    logic             neg_out;

    assign abs_next    = num[NW-1] ? -num : num;
    assign numsh_next  = {{(RW-NM){1'b0}}, maga_reg} << FB;
    assign dentop_next = {{(RW-EW){1'b0}}, dena_reg} << QW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            v_reg[0]  <= 1'b0;
        end
        else
        begin
            va_reg    <= in_valid;
            v_reg[0]  <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        maga_reg   <= abs_next[NM-1:0];
        nega_reg   <= num[NW-1] ^ a_neg;
        dena_reg   <= {a_mag, 1'b0};
        neg_reg[0] <= nega_reg;
        big_reg[0] <= (numsh_next >= dentop_next);
        rem_reg[0] <= numsh_next;
        q_reg[0]   <= '0;
        den_reg[0] <= dena_reg;
    end

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_step
            localparam int K = QW - 1 - g;
            logic [RW-1:0] dsh, rem_next;
            logic [QW-1:0] q_next;
            logic          ge;

            always_comb
            begin
                dsh    = {{(RW-EW){1'b0}}, den_reg[g]} << K;
                ge     = (rem_reg[g] >= dsh);
                q_next = q_reg[g];
                q_next[K] = ge;
                if (ge)
                begin
                    rem_next = rem_reg[g] - dsh;
                end
                else
                begin
                    rem_next = rem_reg[g];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g+1] <= 1'b0;
                end
                else
                begin
                    v_reg[g+1] <= v_reg[g];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g+1] <= rem_next;
                q_reg[g+1]   <= q_next;
                den_reg[g+1] <= den_reg[g];
                neg_reg[g+1] <= neg_reg[g];
                big_reg[g+1] <= big_reg[g];
            end
        end
    endgenerate

    // A quotient of 2^32 or more is flagged up front; its low bits are then meaningless.
    always_comb
    begin
        neg_out = neg_reg[QW] && (big_reg[QW] || (q_reg[QW] != '0));
        if (neg_out)
        begin
            if (big_reg[QW] || (q_reg[QW][QW-1] && (q_reg[QW][QW-2:0] != '0)))
            begin
                root_next = {1'b1, {(QW-1){1'b0}}};
            end
            else
            begin
                root_next = -q_reg[QW];
            end
        end
        else if (big_reg[QW] || q_reg[QW][QW-1])
        begin
            root_next = {1'b0, {(QW-1){1'b1}}};
        end
        else
        begin
            root_next = q_reg[QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign out_valid = vo_reg;
    assign root      = root_reg;

endmodule

@@ hw/rtl/rci_checker.sv @@
// Port-level checks for the ray and cone intersection unit, bound to the top level.
`timescale 1ns / 1ps

module rci_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               done,
    input  logic [1:0]                         hit_status,
    input  logic signed [rci_pkg::IN_W-1:0]    near_root,
    input  logic signed [rci_pkg::IN_W-1:0]    far_root
);

    // Coefficient stages, square root stages, numerator stage and divider stages.
    localparam int LAT = 6 + rci_pkg::ROOT_W + 1 + rci_pkg::DIV_LAT;

    // The pipeline never refuses a request.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a fully pipelined unit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_status == rci_pkg::ST_MISS) || (hit_status == rci_pkg::ST_HIT)
              || (hit_status == rci_pkg::ST_DEGEN))
        else $error("result carries an unused status code");

    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hit_status != rci_pkg::ST_HIT)) |-> (near_root == '0) && (far_root == '0))
        else $error("miss or degenerate result with nonzero roots");

    // Every result strobe goes back to a request exactly one pipeline depth earlier.
    a_done_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching request");

endmodule

bind ray_cone_intersect_unit rci_checker u_rci_checker (.*);

@@ dv/ray_cone_intersect_unit_test.sv @@
// Self-checking testbench for the ray and unit double cone intersection unit.
`timescale 1ns / 1ps

module ray_cone_intersect_unit_test;

    localparam int NUM_RAYS   = 1100;
    localparam int LATENCY    = 108;
    localparam int NUM_DIRECT = 14;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct {
        rci_pkg::status_t   status;
        logic signed [31:0] near_t;
        logic signed [31:0] far_t;
    } hit_t;

    typedef struct {
        ray_t ray;
        bit   typed;
        hit_t hit;
    } direct_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] direction_x = '0, direction_y = '0, direction_z = '0;
    logic done;
    logic [1:0] hit_status;
    logic signed [31:0] near_root, far_root;

    hit_t pending_hits[$];
    int   error_count = 0;
    bit   stim_done = 1'b0;

    ray_cone_intersect_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .direction_x(direction_x), .direction_y(direction_y), .direction_z(direction_z),
        .done(done), .hit_status(hit_status), .near_root(near_root), .far_root(far_root)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [31:0] sat_root(logic signed [259:0] numer,
                                                     logic signed [259:0] coef_a);
        logic signed [259:0] q;
        begin
            // SystemVerilog signed division truncates toward zero, as required.
            q = (numer <<< rci_pkg::FRAC_BITS) / (coef_a * 2);
            if (q > 260'sh7FFFFFFF)
                return 32'h7FFFFFFF;
            if (q < -260'sh80000000)
                return 32'h80000000;
            return q[31:0];
        end
    endfunction

    function automatic hit_t cone_hit(ray_t r);
        logic signed [259:0] a, b, c, d, s, cand;
        hit_t h;
        begin
            a = $signed(r.dx) * $signed(r.dx) - $signed(r.dy) * $signed(r.dy)
                + $signed(r.dz) * $signed(r.dz);
            b = 2 * ($signed(r.ox) * $signed(r.dx) - $signed(r.oy) * $signed(r.dy)
                + $signed(r.oz) * $signed(r.dz));
            c = $signed(r.ox) * $signed(r.ox) - $signed(r.oy) * $signed(r.oy)
                + $signed(r.oz) * $signed(r.oz);
            h.status = rci_pkg::ST_MISS;
            h.near_t = '0;
            h.far_t  = '0;
            if (a == 0)
            begin
                h.status = rci_pkg::ST_DEGEN;
                return h;
            end
            d = b * b - 4 * a * c;
            if (d < 0)
                return h;
            s = '0;
            for (int i = 127; i >= 0; i--)
            begin
                cand = s;
                cand[i] = 1'b1;
                if (cand * cand <= d)
                    s = cand;
            end
            h.status = rci_pkg::ST_HIT;
            h.near_t = sat_root(-b - s, a);
            h.far_t  = sat_root(-b + s, a);
            return h;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    // Result side: sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                hit_t w;
                w = pending_hits.pop_front();
                if (hit_status !== w.status)
                    report_mismatch("hit_status", hit_status, w.status);
                if (near_root !== w.near_t)
                    report_mismatch("near_root", near_root, w.near_t);
                if (far_root !== w.far_t)
                    report_mismatch("far_root", far_root, w.far_t);
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        begin
            case ($urandom_range(0, 5))
                0: return $urandom;
                1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
                2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
                3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
                4: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh3FFFFF;
                default: return '0;
            endcase
        end
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        begin
            r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
            r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
            // Some rays run parallel to the cone surface so that a is zero.
            if ($urandom_range(0, 9) == 0)
            begin
                r.dz = '0;
                r.dy = $urandom_range(0, 1) ? r.dx : -r.dx;
            end
            return r;
        end
    endfunction

    task automatic send_ray(ray_t r, bit typed, hit_t h, bit idle_ok);
        begin
            while (idle_ok && $urandom_range(0, 99) < 14)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start <= 1'b1;
            origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
            direction_x <= r.dx; direction_y <= r.dy; direction_z <= r.dz;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_hits.push_back(typed ? h : cone_hit(r));
            @(negedge clk);
        end
    endtask

    direct_row_t direct_rows[NUM_DIRECT];
    localparam logic signed [31:0] ONE = 32'sh10000;
    localparam logic signed [31:0] MAXV = 32'h7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'h80000000;

    initial
    begin
        ray_t r;
        hit_t none;
        none.status = rci_pkg::ST_MISS;
        none.near_t = '0;
        none.far_t  = '0;
        direct_rows[0]  = '{'{0, 0, 0, 0, 0, 0}, 1, '{rci_pkg::ST_DEGEN, 0, 0}};
        direct_rows[1]  = '{'{0, 0, 0, ONE, ONE, 0}, 1, '{rci_pkg::ST_DEGEN, 0, 0}};
        direct_rows[2]  = '{'{MAXV, MINV, MAXV, 0, 0, 0}, 1, '{rci_pkg::ST_DEGEN, 0, 0}};
        // A ray along the axis at unit distance meets both nappes at t = 1 and t = -1.
        direct_rows[3]  = '{'{ONE, 0, 0, 0, ONE, 0}, 1, '{rci_pkg::ST_HIT, ONE, -ONE}};
        direct_rows[4]  = '{'{0, 0, 0, ONE, 0, 0}, 0, none};
        direct_rows[5]  = '{'{-ONE, 0, 0, ONE, 0, 0}, 0, none};
        direct_rows[6]  = '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 0, none};
        direct_rows[7]  = '{'{MINV, MINV, MINV, MINV, MINV, MINV}, 0, none};
        direct_rows[8]  = '{'{MAXV, 0, MINV, 1, 0, -1}, 0, none};
        direct_rows[9]  = '{'{1, 2, 3, 32'hFFFFFFFF, 0, 1}, 0, none};
        direct_rows[10] = '{'{0, ONE, 0, 0, 0, ONE}, 0, none};
        direct_rows[11] = '{'{MINV, MAXV, 0, 0, 1, 1}, 0, none};
        direct_rows[12] = '{'{5 * ONE, -3 * ONE, 0, -ONE, ONE, ONE}, 0, none};
        direct_rows[13] = '{'{0, 0, MAXV, 0, 1, 2}, 0, none};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (direct_rows[i])
            send_ray(direct_rows[i].ray, direct_rows[i].typed, direct_rows[i].hit, 1'b1);
        for (int n = 0; n < NUM_RAYS; n++)
        begin
            r = rand_ray();
            send_ray(r, 1'b0, none, !(n >= 400 && n < 600));
        end
        start <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("** ray_cone_intersect_unit: PASSED **");
        else
            $display("** ray_cone_intersect_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** ray_cone_intersect_unit: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rci_pkg.sv
hw/rtl/rci_quad.sv
hw/rtl/rci_sqrt.sv
hw/rtl/rci_div.sv
hw/rtl/ray_cone_intersect_unit.sv
hw/rtl/rci_checker.sv
dv/ray_cone_intersect_unit_test.sv
